### design/rvg_pkg.sv
// ============================================================================
// rvg_pkg
// Shared types, constants and the generator step function.
// ============================================================================
package rvg_pkg;

    localparam int unsigned MAX_DRAWS_DEF = 64;
    localparam int unsigned DRAW_W        = 11;
    localparam int unsigned STATE_W       = 48;
    localparam int unsigned IDX_W         = 3;

    localparam logic [1:0] MODE_UNIFORM = 2'd0;
    localparam logic [1:0] MODE_GAUSS   = 2'd1;
    localparam logic [1:0] MODE_MAX     = 2'd2;
    localparam logic [1:0] MODE_MEDIAN  = 2'd3;

    localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCALE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_OFFSET = 3'd2;
    localparam logic [IDX_W-1:0] REG_COUNT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SEED   = 3'd4;

    localparam logic [DRAW_W-1:0] GAUSS_DRAWS  = 11'd12;
    localparam logic [DRAW_W-1:0] MEDIAN_DRAWS = 11'd3;

    localparam logic [23:0] LCG_MUL_LO = 24'hECE66D;
    localparam logic [23:0] LCG_MUL_HI = 24'h0005DE;
    localparam logic [47:0] LCG_ADD    = 48'hB;

    typedef struct packed {
        logic              restart;
        logic [1:0]        mode;
        logic [DRAW_W-1:0] draws;
    } cmd_t;

    typedef struct packed {
        logic [31:0]        scale;
        logic [31:0]        offset;
        logic [STATE_W-1:0] seed;
    } cfg_t;

    function automatic logic [47:0] lcg_next(input logic [47:0] s);
        logic [47:0] lo;
        logic [47:0] mid;
        lo  = 48'(s[23:0]) * 48'(LCG_MUL_LO);
        mid = 48'(s[47:24]) * 48'(LCG_MUL_LO) + 48'(s[23:0]) * 48'(LCG_MUL_HI);
        return lo + {mid[23:0], 24'd0} + LCG_ADD;
    endfunction

endpackage

### design/random_variate_generator.sv
// ============================================================================
// random_variate_generator
// 48-bit linear congruential generator with uniform, twelve-sum Gaussian,
// maximum and median-of-three outputs in signed Q32.32.
// ============================================================================
// Each request takes one generator step per cycle in the back sequencer, so
// the number of draws sets the time per item: a uniform request makes one
// draw, a Gaussian request twelve, a maximum request the configured count
// and a median request three. Uniform and Gaussian results also pass through a
// shared 32 by 31 bit multiplier in two passes, then an add for the scale
// and an add for the offset. A two-entry command queue lets requests be taken
// while the back end is busy, and the result register holds one finished
// value until its transfer completes.
module random_variate_generator #(
    parameter int unsigned MAX_DRAWS = rvg_pkg::MAX_DRAWS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rvg_pkg::IDX_W-1:0] cfg_index,
    input  logic [47:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      restart,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [63:0]               value
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    rvg_pkg::cmd_t push_cmd;
    rvg_pkg::cmd_t pop_cmd;
    rvg_pkg::cfg_t cfg;

    rvg_front #(
        .MAX_DRAWS (MAX_DRAWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .cfg       (cfg)
    );

    rvg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (pop_cmd)
    );

    rvg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

endmodule

### design/rvg_front.sv
// ============================================================================
// rvg_front
// Holds the configuration registers and turns each request into a command.
// ============================================================================
module rvg_front #(
    parameter int unsigned MAX_DRAWS = rvg_pkg::MAX_DRAWS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rvg_pkg::IDX_W-1:0] cfg_index,
    input  logic [47:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      restart,
    input  logic                      q_full,
    output logic                      q_push,
    output rvg_pkg::cmd_t             q_cmd,
    output rvg_pkg::cfg_t             cfg
);

    logic [1:0]  mode_reg;
    logic [31:0] scale_reg;
    logic [31:0] offset_reg;
    logic [6:0]  count_reg;
    logic [47:0] seed_reg;
    logic [rvg_pkg::DRAW_W-1:0] count_ext;
    logic [rvg_pkg::DRAW_W-1:0] draws_max;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign q_push    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= rvg_pkg::MODE_GAUSS;
            scale_reg  <= 32'd65536;
            offset_reg <= 32'd0;
            count_reg  <= 7'd1;
            seed_reg   <= 48'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rvg_pkg::REG_MODE:   mode_reg   <= cfg_data[1:0];
                rvg_pkg::REG_SCALE:  scale_reg  <= cfg_data[31:0];
                rvg_pkg::REG_OFFSET: offset_reg <= cfg_data[31:0];
                rvg_pkg::REG_COUNT:  count_reg  <= cfg_data[6:0];
                rvg_pkg::REG_SEED:   seed_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign count_ext = rvg_pkg::DRAW_W'(count_reg);
    assign draws_max = rvg_pkg::DRAW_W'(MAX_DRAWS);

    always_comb
    begin
        q_cmd.restart = restart;
        q_cmd.mode    = mode_reg;
        case (mode_reg)
            rvg_pkg::MODE_GAUSS:  q_cmd.draws = rvg_pkg::GAUSS_DRAWS;
            rvg_pkg::MODE_MEDIAN: q_cmd.draws = rvg_pkg::MEDIAN_DRAWS;
            rvg_pkg::MODE_MAX:
            begin
                if (count_ext == '0)
                    q_cmd.draws = rvg_pkg::DRAW_W'(1);
                else if (count_ext > draws_max)
                    q_cmd.draws = draws_max;
                else
                    q_cmd.draws = count_ext;
            end
            default:              q_cmd.draws = rvg_pkg::DRAW_W'(1);
        endcase
    end

    assign cfg.scale  = scale_reg;
    assign cfg.offset = offset_reg;
    assign cfg.seed   = seed_reg;

endmodule

### design/rvg_queue.sv
// ============================================================================
// rvg_queue
// Two-entry command queue between the front and the back.
// ============================================================================
module rvg_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rvg_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output rvg_pkg::cmd_t pop_cmd
);

    rvg_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, do_pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

### design/rvg_back.sv
// ============================================================================
// rvg_back
// Runs the generator, combines the draws and scales the result.
// ============================================================================
module rvg_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  rvg_pkg::cmd_t q_cmd,
    output logic          q_pop,
    input  rvg_pkg::cfg_t cfg,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   value
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DRAW   = 7'b0000010,
        ST_MUL_LO = 7'b0000100,
        ST_MUL_HI = 7'b0001000,
        ST_SUM    = 7'b0010000,
        ST_OFFS   = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    state_t                     state_reg;
    logic [47:0]                gen_reg;
    logic [1:0]                 mode_reg;
    logic [rvg_pkg::DRAW_W-1:0] left_reg;
    logic                       first_reg;
    logic [51:0]                acc_reg;
    logic [47:0]                a_reg;
    logic [47:0]                b_reg;
    logic signed [53:0]         m_reg;
    logic signed [62:0]         p0_reg;
    logic signed [62:0]         p1_reg;
    logic [55:0]                sc_reg;
    logic [63:0]                res_reg;
    logic                       out_valid_reg;
    logic [63:0]                value_reg;

    logic [47:0]        nxt;
    logic [51:0]        sum;
    logic [47:0]        best;
    logic [47:0]        lo;
    logic [47:0]        hi;
    logic [47:0]        mid;
    logic signed [30:0] mul_b;
    logic signed [62:0] prod;
    logic signed [87:0] full;
    logic               slot_free;

    assign nxt = rvg_pkg::lcg_next(gen_reg);
    assign sum = acc_reg + 52'(nxt);

    always_comb
    begin
        if (first_reg || nxt > acc_reg[47:0])
            best = nxt;
        else
            best = acc_reg[47:0];
        lo = (a_reg < b_reg) ? a_reg : b_reg;
        hi = (a_reg < b_reg) ? b_reg : a_reg;
        mid = (hi < nxt) ? hi : nxt;
        if (lo > mid)
            mid = lo;
    end

    assign mul_b = (state_reg == ST_MUL_LO) ? $signed({7'd0, m_reg[23:0]})
                                            : $signed({m_reg[53], m_reg[53:24]});
    assign prod  = $signed(cfg.scale) * mul_b;
    assign full  = (88'(p1_reg) <<< 24) + 88'(p0_reg);

    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DRAW:
            begin
                if (left_reg == rvg_pkg::DRAW_W'(1))
                begin
                    case (mode_reg)
                        rvg_pkg::MODE_UNIFORM: m_reg <= $signed({6'd0, nxt});
                        rvg_pkg::MODE_GAUSS:
                            m_reg <= $signed({2'd0, sum}) - $signed(54'(6) <<< 48);
                        rvg_pkg::MODE_MAX:     res_reg <= {32'd0, best[47:16]};
                        default:               res_reg <= {32'd0, mid[47:16]};
                    endcase
                end
                else
                begin
                    acc_reg <= (mode_reg == rvg_pkg::MODE_GAUSS)
                               ? (first_reg ? 52'(nxt) : sum) : 52'(best);
                    if (first_reg)
                        a_reg <= nxt;
                    else
                        b_reg <= nxt;
                end
            end
            ST_MUL_LO: p0_reg <= prod;
            ST_MUL_HI: p1_reg <= prod;
            ST_SUM:    sc_reg <= full[87:32];
            ST_OFFS:
                res_reg <= 64'($signed(sc_reg))
                           + {{16{cfg.offset[31]}}, cfg.offset, 16'd0};
            default:   ;
        endcase
        if (state_reg == ST_FIN && slot_free)
            value_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= 48'd0;
            mode_reg      <= rvg_pkg::MODE_GAUSS;
            left_reg      <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_FIN && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_cmd.restart)
                            gen_reg <= cfg.seed;
                        mode_reg  <= q_cmd.mode;
                        left_reg  <= q_cmd.draws;
                        first_reg <= 1'b1;
                        state_reg <= ST_DRAW;
                    end
                end
                ST_DRAW:
                begin
                    gen_reg   <= nxt;
                    first_reg <= 1'b0;
                    left_reg  <= left_reg - rvg_pkg::DRAW_W'(1);
                    if (left_reg == rvg_pkg::DRAW_W'(1))
                    begin
                        if (mode_reg == rvg_pkg::MODE_UNIFORM ||
                            mode_reg == rvg_pkg::MODE_GAUSS)
                            state_reg <= ST_MUL_LO;
                        else
                            state_reg <= ST_FIN;
                    end
                end
                ST_MUL_LO: state_reg <= ST_MUL_HI;
                ST_MUL_HI: state_reg <= ST_SUM;
                ST_SUM:    state_reg <= ST_OFFS;
                ST_OFFS:   state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (slot_free)
                        state_reg <= ST_IDLE;
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
